>>> src/eses_pkg.sv
// Shared types and constants for the encoder speed estimator.
`default_nettype none

package eses_pkg;

    // Field and state widths
    localparam int CNT_W      = 12;
    localparam int THR_W      = 12;
    localparam int TICK_W     = 16;
    localparam int TOUT_W     = 24;
    localparam int ELAPSED_W  = 25;
    localparam int SPEED_W    = 26;
    localparam int EVENT_W    = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;

    // Quotient is at most 25 bits once the saturation check has passed
    localparam int QUOT_W     = 25;
    localparam int DIV_CNT_W  = $clog2(QUOT_W);

    // Microseconds per minute and the product of it with a 12-bit magnitude
    localparam int USPM_W     = 26;
    localparam logic [USPM_W-1:0] US_PER_MIN = USPM_W'(60000000);
    localparam int DIVIDEND_W = CNT_W + USPM_W;

    localparam logic [QUOT_W-1:0] SPEED_LIMIT = QUOT_W'(30000000);

    // Result event codes
    localparam logic [EVENT_W-1:0] EV_HOLD    = 2'd0;
    localparam logic [EVENT_W-1:0] EV_MEASURE = 2'd1;
    localparam logic [EVENT_W-1:0] EV_TIMEOUT = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MOVE_THR = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TICK_US  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT  = 2'd2;

    // Configuration reset values
    localparam logic [THR_W-1:0]  MOVE_THR_RST = THR_W'(2);
    localparam logic [TICK_W-1:0] TICK_US_RST  = TICK_W'(1000);
    localparam logic [TOUT_W-1:0] TIMEOUT_RST  = TOUT_W'(500000);

    // Controller to datapath commands
    typedef struct packed {
        logic load;      // capture the input item
        logic eval;      // update time, compare movement, pick event
        logic mul;       // form dividend and divisor
        logic pre;       // saturation check and divider setup
        logic step;      // one restoring division step
        logic fin;       // clamp, apply sign, store speed
        logic out_load;  // move result into output register
    } cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic moved;     // movement threshold exceeded
        logic sat;       // quotient known to exceed the limit
    } stat_t;

endpackage

`default_nettype wire

>>> src/eses_ctrl.sv
// Sequencing state machine and output valid flag for the speed estimator.
`default_nettype none

module eses_ctrl (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    output logic                 in_ready,
    output logic                 out_valid,
    input  wire logic            out_ready,
    input  wire eses_pkg::stat_t stat,
    output eses_pkg::cmd_t       cmd
);
    import eses_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_EVAL = 3'd1;
    localparam logic [2:0] S_MUL  = 3'd2;
    localparam logic [2:0] S_PRE  = 3'd3;
    localparam logic [2:0] S_DIV  = 3'd4;
    localparam logic [2:0] S_FIN  = 3'd5;
    localparam logic [2:0] S_OUT  = 3'd6;

    localparam logic [DIV_CNT_W-1:0] CNT_INIT = DIV_CNT_W'(QUOT_W - 1);

    logic [2:0]           state_reg;
    logic [2:0]           state_next;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [DIV_CNT_W-1:0] cnt_next;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic                 out_free;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_free  = !out_valid_reg || out_ready;

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_EVAL;
                end
            end
            S_EVAL:
            begin
                cmd.eval   = 1'b1;
                state_next = stat.moved ? S_MUL : S_OUT;
            end
            S_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = S_PRE;
            end
            S_PRE:
            begin
                cmd.pre    = 1'b1;
                cnt_next   = CNT_INIT;
                state_next = stat.sat ? S_FIN : S_DIV;
            end
            S_DIV:
            begin
                cmd.step = 1'b1;
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                cmd.fin    = 1'b1;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Output valid: set on load, cleared when the item is taken
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // An accepted item blocks the input for at least the next cycle
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input ready right after accepting an item");

    // A loaded result is presented on the next cycle
    a_out_after_load: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |=> out_valid)
        else $error("result loaded but not presented");

    // A presented result stays until it is taken
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped before it was taken");

endmodule

`default_nettype wire

>>> src/eses_datapath.sv
// Datapath: configuration, estimator state, multipliers and restoring divider.
`default_nettype none

module eses_datapath #(
    parameter int ENC_SPAN = 4096
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_valid,
    input  wire logic [eses_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [eses_pkg::CFG_DATA_W-1:0] cfg_data,
    input  wire logic [eses_pkg::CNT_W-1:0]     enc_count,
    input  wire eses_pkg::cmd_t                 cmd,
    output eses_pkg::stat_t                     stat,
    output logic [eses_pkg::SPEED_W-1:0]        speed_out,
    output logic [eses_pkg::EVENT_W-1:0]        event_out
);
    import eses_pkg::*;

    localparam int SPAN_W = $clog2(ENC_SPAN + 1);
    localparam int WW     = ((SPAN_W > CNT_W) ? SPAN_W : CNT_W) + 2;
    localparam int DVW    = SPAN_W + ELAPSED_W;
    localparam int RW     = DVW + 1;
    localparam int CMP_W  = DVW + QUOT_W;

    localparam logic [SPAN_W-1:0]    SPAN_C = SPAN_W'(ENC_SPAN);
    localparam logic signed [WW-1:0] SPAN_S = WW'(ENC_SPAN);
    localparam logic signed [WW-1:0] HALF_S = WW'(ENC_SPAN / 2);

    // Configuration registers
    logic [THR_W-1:0]  move_thr_reg;
    logic [TICK_W-1:0] tick_us_reg;
    logic [TOUT_W-1:0] timeout_reg;

    // Estimator state
    logic [CNT_W-1:0]     last_count_reg;
    logic [ELAPSED_W-1:0] elapsed_reg;
    logic [SPEED_W-1:0]   speed_value_reg;
    logic [EVENT_W-1:0]   event_reg;

    // Work registers
    logic [CNT_W-1:0]      cur_reg;
    logic                  neg_reg;
    logic [CNT_W-1:0]      dmag_reg;
    logic [ELAPSED_W-1:0]  meas_el_reg;
    logic [DIVIDEND_W-1:0] dividend_reg;
    logic [DVW-1:0]        divisor_reg;
    logic                  sat_reg;
    logic [RW-1:0]         rem_reg;
    logic [QUOT_W-1:0]     quo_reg;
    logic [SPEED_W-1:0]    speed_out_reg;
    logic [EVENT_W-1:0]    event_out_reg;

    // Combinational terms
    logic [ELAPSED_W:0]        el_sum;
    logic [ELAPSED_W-1:0]      t_sat;
    logic                      timed_out;
    logic signed [CNT_W:0]     raw;
    logic signed [CNT_W:0]     raw_abs;
    logic signed [WW-1:0]      raw_w;
    logic signed [WW-1:0]      d_wrap;
    logic signed [WW-1:0]      d_abs;
    logic [ELAPSED_W-1:0]      el_nz;
    logic [DIVIDEND_W-1:0]     dividend_prod;
    logic [DVW-1:0]            divisor_prod;
    logic [CMP_W-1:0]          cmp_lhs;
    logic [CMP_W-1:0]          cmp_rhs;
    logic [RW-1:0]             rem_sh;
    logic                      rem_ge;
    logic [QUOT_W-1:0]         quo_clamped;
    logic [SPEED_W-1:0]        quo_ext;

    // Elapsed time with saturation, then the timeout compare
    assign el_sum    = {1'b0, elapsed_reg} + (ELAPSED_W + 1)'(tick_us_reg);
    assign t_sat     = el_sum[ELAPSED_W] ? '1 : el_sum[ELAPSED_W-1:0];
    assign timed_out = (t_sat > ELAPSED_W'(timeout_reg));

    // Raw difference for the threshold, wrapped difference for the speed
    assign raw        = $signed({1'b0, cur_reg}) - $signed({1'b0, last_count_reg});
    assign raw_abs    = raw[CNT_W] ? -raw : raw;
    assign stat.moved = (raw_abs[CNT_W-1:0] > move_thr_reg);
    assign raw_w      = WW'(raw);

    always_comb
    begin
        if (raw_w > HALF_S)
        begin
            d_wrap = raw_w - SPAN_S;
        end
        else if (raw_w < -HALF_S)
        begin
            d_wrap = raw_w + SPAN_S;
        end
        else
        begin
            d_wrap = raw_w;
        end
    end

    assign d_abs = d_wrap[WW-1] ? -d_wrap : d_wrap;

    // Products: |delta| * us per minute, span * elapsed (zero counts as one)
    assign el_nz         = (meas_el_reg == '0) ? ELAPSED_W'(1) : meas_el_reg;
    assign dividend_prod = {{(DIVIDEND_W - CNT_W){1'b0}}, dmag_reg}
                         * {{(DIVIDEND_W - USPM_W){1'b0}}, US_PER_MIN};
    assign divisor_prod  = {{(DVW - SPAN_W){1'b0}}, SPAN_C}
                         * {{(DVW - ELAPSED_W){1'b0}}, el_nz};

    // Quotient would need more than QUOT_W bits
    assign cmp_lhs  = CMP_W'(dividend_reg);
    assign cmp_rhs  = {divisor_reg, {QUOT_W{1'b0}}};
    assign stat.sat = (cmp_lhs >= cmp_rhs);

    // One restoring step: shift in the next dividend bit, try to subtract
    assign rem_sh = {rem_reg[RW-2:0], quo_reg[QUOT_W-1]};
    assign rem_ge = (rem_sh >= {1'b0, divisor_reg});

    // Clamp and widen for signing
    assign quo_clamped = (sat_reg || (quo_reg > SPEED_LIMIT)) ? SPEED_LIMIT : quo_reg;
    assign quo_ext     = {1'b0, quo_clamped};

    // Configuration writes; indexes past the list are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            move_thr_reg <= MOVE_THR_RST;
            tick_us_reg  <= TICK_US_RST;
            timeout_reg  <= TIMEOUT_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_MOVE_THR: move_thr_reg <= cfg_data[THR_W-1:0];
                REG_TICK_US:  tick_us_reg  <= cfg_data[TICK_W-1:0];
                REG_TIMEOUT:  timeout_reg  <= cfg_data[TOUT_W-1:0];
                default:      ;
            endcase
        end
    end

    // Estimator state: count, elapsed time, speed, event
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_count_reg  <= '0;
            elapsed_reg     <= '0;
            speed_value_reg <= '0;
            event_reg       <= EV_HOLD;
        end
        else if (cmd.eval)
        begin
            if (stat.moved)
            begin
                last_count_reg <= cur_reg;
                elapsed_reg    <= '0;
                event_reg      <= EV_MEASURE;
            end
            else if (timed_out)
            begin
                last_count_reg  <= cur_reg;
                elapsed_reg     <= '0;
                speed_value_reg <= '0;
                event_reg       <= EV_TIMEOUT;
            end
            else
            begin
                elapsed_reg <= t_sat;
                event_reg   <= EV_HOLD;
            end
        end
        else if (cmd.fin)
        begin
            speed_value_reg <= neg_reg ? (~quo_ext + 1'b1) : quo_ext;
        end
    end

    // Work registers for the measurement path
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            cur_reg <= enc_count;
        end
        if (cmd.eval)
        begin
            neg_reg     <= d_wrap[WW-1];
            dmag_reg    <= d_abs[CNT_W-1:0];
            meas_el_reg <= t_sat;
        end
        if (cmd.mul)
        begin
            dividend_reg <= dividend_prod;
            divisor_reg  <= divisor_prod;
        end
        if (cmd.pre)
        begin
            sat_reg <= stat.sat;
            rem_reg <= RW'(dividend_reg[DIVIDEND_W-1:QUOT_W]);
            quo_reg <= dividend_reg[QUOT_W-1:0];
        end
        else if (cmd.step)
        begin
            rem_reg <= rem_ge ? (rem_sh - {1'b0, divisor_reg}) : rem_sh;
            quo_reg <= {quo_reg[QUOT_W-2:0], rem_ge};
        end
        if (cmd.out_load)
        begin
            speed_out_reg <= speed_value_reg;
            event_out_reg <= event_reg;
        end
    end

    assign speed_out = speed_out_reg;
    assign event_out = event_out_reg;

    // Partial remainder stays below the divisor between steps
    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.step |-> (rem_reg < {1'b0, divisor_reg}))
        else $error("divider remainder not below divisor");

    // A measurement or timeout restarts the elapsed time
    a_elapsed_clear: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.eval && (stat.moved || timed_out) |=> (elapsed_reg == '0))
        else $error("elapsed time not cleared");

    // Stored speed never leaves the clamp range
    a_speed_range: assert property (@(posedge clk) disable iff (!rst_n)
        ($signed(speed_value_reg) <= $signed({1'b0, SPEED_LIMIT}))
        && ($signed(speed_value_reg) >= -$signed({1'b0, SPEED_LIMIT})))
        else $error("speed estimate out of range");

endmodule

`default_nettype wire

>>> src/encoder_speed_estimator.sv
// A held or timeout item goes through the evaluate and output states; a measurement also goes
// through multiply, divider setup, the 25-step restoring divider (skipped if it saturates) and
// finish. A new item is accepted only in idle, once the previous result has been loaded out;
// a waiting result does not stop the next item from being accepted, but its result waits until the output is free.
// Reset: registers return to their defaults, count, time and speed clear to zero,
// and no result is pending.
`default_nettype none

module encoder_speed_estimator #(
    parameter int ENC_SPAN = 4096
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [eses_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [eses_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  wire logic                             in_valid,
    output logic                                  in_ready,
    input  wire logic [eses_pkg::CNT_W-1:0]       enc_count,
    output logic                                  out_valid,
    input  wire logic                             out_ready,
    output logic signed [eses_pkg::SPEED_W-1:0]   speed_rpm,
    output logic [eses_pkg::EVENT_W-1:0]          event_res
);
    import eses_pkg::*;

    cmd_t               cmd;
    stat_t              stat;
    logic [SPEED_W-1:0] speed_out;

    // Register writes are taken in any cycle
    assign cfg_ready = 1'b1;

    eses_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    eses_datapath #(
        .ENC_SPAN (ENC_SPAN)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .enc_count (enc_count),
        .cmd       (cmd),
        .stat      (stat),
        .speed_out (speed_out),
        .event_out (event_res)
    );

    assign speed_rpm = $signed(speed_out);

endmodule

`default_nettype wire

>>> tb/sv/tb_top.sv
// Self-checking testbench for the encoder speed estimator: random ticks, settings and flow control.
module tb_top;

    import eses_pkg::*;

    localparam int SPAN = 4096;

    // Index past the end of the register list; writes to it are dropped
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    localparam longint US_PER_MINUTE = 64'd60000000;
    localparam longint RPM_CAP       = 64'd30000000;
    localparam longint ELAPSED_SAT   = 64'h1FF_FFFF;
    localparam int     RANDOM_ITEMS  = 1525;

    typedef struct {
        logic signed [SPEED_W-1:0] spd;
        logic [EVENT_W-1:0]        ev;
    } speed_result_t;

    typedef struct {
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] data;
    } reg_write_t;

    typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_SPARSE, RX_HELD} rx_mode_t;

    logic                       clk       = 1'b0;
    logic                       rst_n     = 1'b0;
    logic                       cfg_valid = 1'b0;
    logic                       cfg_ready;
    logic [CFG_IDX_W-1:0]       cfg_index = REG_MOVE_THR;
    logic [CFG_DATA_W-1:0]      cfg_data  = '0;
    logic                       in_valid  = 1'b0;
    logic                       in_ready;
    logic [CNT_W-1:0]           enc_count = '0;
    logic                       out_valid;
    logic                       out_ready = 1'b0;
    logic signed [SPEED_W-1:0]  speed_rpm;
    logic [EVENT_W-1:0]         event_res;

    // Predicted register and state copies
    logic [THR_W-1:0]           move_thr  = MOVE_THR_RST;
    logic [TICK_W-1:0]          tick_us   = TICK_US_RST;
    logic [TOUT_W-1:0]          timeout   = TIMEOUT_RST;
    logic [CNT_W-1:0]           last_cnt  = '0;
    logic [ELAPSED_W-1:0]       elapsed   = '0;
    logic signed [SPEED_W-1:0]  speed_est = '0;

    logic [CNT_W-1:0] count_q[$];
    speed_result_t    speed_expect_q[$];
    reg_write_t       reg_write_q[$];

    int       mismatches = 0;
    int       burst_left = 0;
    int       gap_left   = 0;
    int       stall_left = 0;
    rx_mode_t stall_mode = RX_OPEN;
    int       enc_pos    = 0;

    encoder_speed_estimator #(
        .ENC_SPAN (SPAN)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .enc_count (enc_count),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .speed_rpm (speed_rpm),
        .event_res (event_res)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Tick update: accumulate time, then measure, time out or hold
    function automatic void predict_speed(input logic [CNT_W-1:0] cnt);
        longint        t;
        longint        raw;
        longint        mag;
        longint        d;
        longint        q;
        longint        dv;
        speed_result_t r;
        t = longint'(elapsed) + longint'(tick_us);
        if (t > ELAPSED_SAT)
            t = ELAPSED_SAT;
        elapsed = ELAPSED_W'(t);
        raw = longint'(cnt) - longint'(last_cnt);
        mag = (raw < 0) ? -raw : raw;
        r.ev = EV_HOLD;
        if (mag > longint'(move_thr))
        begin
            // unwrap once into half a turn either way
            d = raw;
            if (d > SPAN / 2)
                d = d - SPAN;
            else if (d < -(SPAN / 2))
                d = d + SPAN;
            // zero time counts as one microsecond
            dv = longint'(SPAN) * ((elapsed == 0) ? 64'd1 : longint'(elapsed));
            q = (((d < 0) ? -d : d) * US_PER_MINUTE) / dv;
            if (q > RPM_CAP)
                q = RPM_CAP;
            speed_est = SPEED_W'((d < 0) ? -q : q);
            last_cnt  = cnt;
            elapsed   = '0;
            r.ev      = EV_MEASURE;
        end
        else if (longint'(elapsed) > longint'(timeout))
        begin
            speed_est = '0;
            last_cnt  = cnt;
            elapsed   = '0;
            r.ev      = EV_TIMEOUT;
        end
        r.spd = speed_est;
        speed_expect_q.insert(speed_expect_q.size(), r);
    endfunction

    // Queue a register write; bits above the register width are junk
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
        reg_write_t w;
        w.idx  = idx;
        w.data = CFG_DATA_W'($urandom);
        case (idx)
            REG_MOVE_THR: w.data[THR_W-1:0]  = THR_W'(value);
            REG_TICK_US:  w.data[TICK_W-1:0] = TICK_W'(value);
            REG_TIMEOUT:  w.data             = TOUT_W'(value);
            default:      ;
        endcase
        reg_write_q.insert(reg_write_q.size(), w);
    endtask

    // Block until every queued item and write is through and all results are back
    task automatic wait_idle();
        do
            @(negedge clk);
        while (count_q.size() != 0 || in_valid || speed_expect_q.size() != 0 ||
               reg_write_q.size() != 0 || cfg_valid);
        repeat (4) @(negedge clk);
    endtask

    // Random settings, extremes weighted in
    task automatic random_settings();
        int thr;
        int tick;
        int tmo;
        case ($urandom_range(0, 5))
            0:       thr = 0;
            1:       thr = 4095;
            2:       thr = $urandom_range(1, 8);
            3:       thr = $urandom_range(0, 4095);
            default: thr = $urandom_range(0, 64);
        endcase
        case ($urandom_range(0, 11))
            0:       tick = 0;
            1:       tick = 65535;
            2:       tick = 1;
            3:       tick = 1000;
            default: tick = $urandom_range(1, 65535);
        endcase
        case ($urandom_range(0, 4))
            0:       tmo = 1;
            1:       tmo = 24'hFF_FFFF;
            2:       tmo = $urandom_range(1, 24'hFF_FFFF);
            default: tmo = tick * $urandom_range(1, 30);
        endcase
        if (tmo > 24'hFF_FFFF)
            tmo = 24'hFF_FFFF;
        if (tmo < 1)
            tmo = 1;
        write_reg(REG_MOVE_THR, thr);
        write_reg(REG_TIMEOUT, tmo);
        write_reg(REG_TICK_US, tick);
        if ($urandom_range(0, 5) == 0)
            write_reg(REG_UNUSED, 0);
    endtask

    // Encoder motion: steady velocity with jitter, parked shaft, or raw noise
    task automatic motion_items(input int n);
        int vel;
        int jit;
        int style;
        style = $urandom_range(0, 9);
        case (style)
            0, 1:    vel = 0;
            2, 3:    vel = int'($urandom_range(0, 8)) - 4;
            default: vel = int'($urandom_range(0, 600)) - 300;
        endcase
        for (int k = 0; k < n; k++)
        begin
            if (style == 0 || $urandom_range(0, 39) == 0)
                enc_pos = $urandom_range(0, SPAN - 1);
            else
            begin
                if ($urandom_range(0, 19) == 0)
                    vel = int'($urandom_range(0, SPAN)) - SPAN / 2;
                jit = (style == 1) ? int'($urandom_range(0, 2)) - 1
                                   : int'($urandom_range(0, 6)) - 3;
                enc_pos = (enc_pos + vel + jit) & (SPAN - 1);
            end
            count_q.insert(count_q.size(), CNT_W'(enc_pos));
        end
    endtask

    // Register write driver; predicted settings follow each accepted write
    always @(posedge clk or negedge rst_n)
    begin : reg_driver
        reg_write_t w;
        if (!rst_n)
        begin
            cfg_valid <= 1'b0;
            cfg_index <= REG_MOVE_THR;
            cfg_data  <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_MOVE_THR: move_thr = cfg_data[THR_W-1:0];
                    REG_TICK_US:  tick_us  = cfg_data[TICK_W-1:0];
                    REG_TIMEOUT:  timeout  = cfg_data[TOUT_W-1:0];
                    default:      ;
                endcase
            end
            if (!cfg_valid || cfg_ready)
            begin
                if (reg_write_q.size() > 0)
                begin
                    w = reg_write_q.pop_front();
                    cfg_valid <= 1'b1;
                    cfg_index <= w.idx;
                    cfg_data  <= w.data;
                end
                else
                    cfg_valid <= 1'b0;
            end
        end
    end

    // Tick driver: bursts of items separated by random gaps
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid  <= 1'b0;
            enc_count <= '0;
        end
        else
        begin
            if (in_valid && in_ready)
                predict_speed(enc_count);
            if (!in_valid || in_ready)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (count_q.size() > 0)
                begin
                    in_valid  <= 1'b1;
                    enc_count <= count_q.pop_front();
                    if (burst_left == 0)
                        burst_left = $urandom_range(1, 32);
                    burst_left--;
                    if (burst_left == 0)
                    begin
                        case ($urandom_range(0, 3))
                            1:       gap_left = $urandom_range(1, 4);
                            2:       gap_left = $urandom_range(5, 40);
                            default: gap_left = 0;
                        endcase
                    end
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Result back-pressure: open, coin flip, sparse or held, in random runs
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (stall_left == 0)
            begin
                stall_mode = rx_mode_t'($urandom_range(0, 3));
                stall_left = $urandom_range(1, 80);
            end
            stall_left--;
            case (stall_mode)
                RX_OPEN:   out_ready <= 1'b1;
                RX_COIN:   out_ready <= 1'($urandom_range(0, 1));
                RX_SPARSE: out_ready <= ($urandom_range(0, 7) == 0);
                default:   out_ready <= 1'b0;
            endcase
        end
    end

    // Result checker
    always @(posedge clk)
    begin : result_check
        speed_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (speed_expect_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: speed %0d event %0d", speed_rpm, event_res);
            end
            else
            begin
                want = speed_expect_q.pop_front();
                if (speed_rpm !== want.spd || event_res !== want.ev)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: speed exp %0d got %0d, event exp %0d got %0d",
                                 want.spd, speed_rpm, want.ev, event_res);
                end
            end
        end
    end

    // Stimulus phases
    initial
    begin : stimulus
        int sent;
        int n;
        sent = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset settings: holds, first move, wrap both ways, half-turn steps
        count_q = '{12'd0, 12'd2, 12'd3, 12'd4095, 12'd2047, 12'd4095, 12'd0, 12'd1,
                    12'hAAA, 12'h555};
        wait_idle();

        // zero tick time and zero threshold; full-scale speeds both ways
        write_reg(REG_TICK_US, 0);
        write_reg(REG_MOVE_THR, 0);
        write_reg(REG_UNUSED, 24'hFF_FFFF);
        wait_idle();
        count_q = '{12'd0, 12'd2048, 12'd0, 12'd0, 12'd1};
        wait_idle();

        // largest tick, shortest timeout, threshold never exceeded: every tick times out
        write_reg(REG_TICK_US, 65535);
        write_reg(REG_TIMEOUT, 1);
        write_reg(REG_MOVE_THR, 4095);
        wait_idle();
        count_q = '{12'd4095, 12'd0, 12'h800, 12'd7};
        wait_idle();

        // smallest tick, longest timeout: pure holds
        write_reg(REG_TICK_US, 1);
        write_reg(REG_TIMEOUT, 24'hFF_FFFF);
        wait_idle();
        count_q = '{12'd0, 12'd4095, 12'd0};
        wait_idle();

        // random phases, new settings each time
        while (sent < RANDOM_ITEMS)
        begin
            random_settings();
            wait_idle();
            n = $urandom_range(60, 140);
            if (n > RANDOM_ITEMS - sent)
                n = RANDOM_ITEMS - sent;
            motion_items(n);
            sent += n;
            wait_idle();
        end

        repeat (40) @(posedge clk);
        if (mismatches == 0 && speed_expect_q.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // Watchdog
    initial
    begin
        #20000000;
        $display("== FAIL ==");
        $finish;
    end

endmodule

>>> sim.f
src/eses_pkg.sv
src/eses_ctrl.sv
src/eses_datapath.sv
src/encoder_speed_estimator.sv
tb/sv/tb_top.sv
